[src/smf_pkg.sv]
// Shared types and codes for the stereo soft-mute fader.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none

package smf_pkg;

   // Input function codes as they arrive on the request channel
   localparam int FUNC_BITS = 3;
   localparam logic [FUNC_BITS-1:0] FUNC_FRAME     = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_FADE_OUT  = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_FADE_IN   = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_FORCE_MUTE = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_FORCE_PLAY = 3'd4;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_SAMPLES = 1'b0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FADE_CURVE   = 1'b1;

   localparam int FADE_SAMPLES_RESET = 2400;

   // Queue between the front and the back
   localparam int QUEUE_DEPTH = 2;

   // Classified operation carried through the queue
   localparam int OP_BITS = 3;
   typedef enum logic [OP_BITS-1:0] {
      OP_FRAME,
      OP_FADE_OUT,
      OP_FADE_IN,
      OP_MUTE,
      OP_PLAY,
      OP_NOP
   } op_type;

   // Fader state as reported on the result channel
   typedef enum logic [1:0] {
      ST_PLAYING  = 2'd0,
      ST_FADE_OUT = 2'd1,
      ST_MUTED    = 2'd2,
      ST_FADE_IN  = 2'd3
   } mode_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

   typedef struct packed {
      logic start;
      logic is_sqrt;
   } arith_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } arith_stat_type;

endpackage

`default_nettype wire

[src/stereo_soft_mute_fader.sv]
// Top level of the stereo soft-mute fader: classifier, queue, fade
// sequencer and shared divide/root unit. Depends on smf_pkg and all smf_ modules.
//
//   channel  direction  handshake            payload
//   req_     in         req_valid/req_ready  func, left/right sample, last_frame
//   rsp_     out        rsp_valid/rsp_ready  left/right out, gain, state, silent, last
//   csr_     in         csr_we               csr_index, csr_wdata
//
// Commands and frames in the playing or muted state go straight to the send step
// of the sequencer, and a frame that ends a fade passes the scale step first. A fade
// frame waits for a division in the shared one-bit-per-cycle divide/root unit, then a
// square (power fade in) or a root in that unit (power fade out). Items are processed one
// at a time; a two-beat queue takes new beats while the sequencer works or the
// result waits. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module stereo_soft_mute_fader
   import smf_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int GAIN_FRAC_BITS = 15,
   parameter int POSITION_BITS  = 20
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [FUNC_BITS-1:0]          req_func,
   input  wire logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  wire logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  wire logic                          req_last_frame,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right_out,
   output logic [GAIN_FRAC_BITS:0]            rsp_gain_now,
   output logic [1:0]                         rsp_mute_state,
   output logic                               rsp_silent,
   output logic                               rsp_last_out,
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [POSITION_BITS-1:0]      csr_wdata
);

   localparam int GW        = GAIN_FRAC_BITS + 1;
   localparam int ITEM_BITS = OP_BITS + 2 * SAMPLE_BITS + 1;
   localparam logic [GW-1:0] GAIN_ONE = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

   queue_stat_type           q_stat;
   logic                     push;
   logic [ITEM_BITS-1:0]     push_data;
   logic                     pop;
   logic [ITEM_BITS-1:0]     pop_data;
   arith_ctl_type            arith_ctl;
   arith_stat_type           arith_stat;
   logic [POSITION_BITS-1:0] arith_num;
   logic [POSITION_BITS-1:0] arith_den;
   logic [GW-1:0]            arith_rad;
   logic [GW-1:0]            arith_result;

   smf_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_left_sample  (req_left_sample),
      .req_right_sample (req_right_sample),
      .req_last_frame   (req_last_frame),
      .q_stat           (q_stat),
      .push             (push),
      .push_data        (push_data)
   );

   smf_queue #(
      .WIDTH (ITEM_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .q_stat    (q_stat)
   );

   smf_arith #(
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .POSITION_BITS  (POSITION_BITS)
   ) u_arith (
      .clock  (clock),
      .reset  (reset),
      .ctl    (arith_ctl),
      .num    (arith_num),
      .den    (arith_den),
      .rad    (arith_rad),
      .stat   (arith_stat),
      .result (arith_result)
   );

   smf_back #(
      .SAMPLE_BITS    (SAMPLE_BITS),
      .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
      .POSITION_BITS  (POSITION_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .q_stat         (q_stat),
      .pop            (pop),
      .pop_data       (pop_data),
      .arith_ctl      (arith_ctl),
      .arith_num      (arith_num),
      .arith_den      (arith_den),
      .arith_rad      (arith_rad),
      .arith_stat     (arith_stat),
      .arith_result   (arith_result),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_left_out   (rsp_left_out),
      .rsp_right_out  (rsp_right_out),
      .rsp_gain_now   (rsp_gain_now),
      .rsp_mute_state (rsp_mute_state),
      .rsp_silent     (rsp_silent),
      .rsp_last_out   (rsp_last_out)
   );

   // the divide/root unit is never restarted in the middle of a run
   a_arith_start_idle: assert property (@(posedge clock) disable iff (reset)
      arith_ctl.start |-> !arith_stat.busy)
      else $error("arith unit started while busy");

   // a pop never drains an empty queue
   a_pop_not_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("pop from empty queue");

   // the playing state always carries unity gain
   a_playing_unity: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mute_state == ST_PLAYING) |-> (rsp_gain_now == GAIN_ONE))
      else $error("playing state with gain other than unity");

   // the muted state always carries zero gain
   a_muted_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mute_state == ST_MUTED) |-> (rsp_gain_now == '0))
      else $error("muted state with nonzero gain");

endmodule

`default_nettype wire

[src/smf_front.sv]
// Front end: accepts request beats, classifies the function code and pushes
// the packed item into the queue. Depends on smf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smf_front
   import smf_pkg::*;
#(
   parameter int SAMPLE_BITS = 24,
   localparam int ITEM_BITS = OP_BITS + 2 * SAMPLE_BITS + 1
) (
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [FUNC_BITS-1:0]          req_func,
   input  wire logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  wire logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  wire logic                          req_last_frame,
   input  queue_stat_type                     q_stat,
   output logic                               push,
   output logic [ITEM_BITS-1:0]               push_data
);

   op_type op;

   always_comb begin
      case (req_func)
         FUNC_FRAME:      op = OP_FRAME;
         FUNC_FADE_OUT:   op = OP_FADE_OUT;
         FUNC_FADE_IN:    op = OP_FADE_IN;
         FUNC_FORCE_MUTE: op = OP_MUTE;
         FUNC_FORCE_PLAY: op = OP_PLAY;
         default:         op = OP_NOP;
      endcase
   end

   assign req_ready = ~q_stat.full;
   assign push      = req_valid & ~q_stat.full;
   assign push_data = {op, req_left_sample, req_right_sample, req_last_frame};

endmodule

`default_nettype wire

[src/smf_queue.sv]
// Short FIFO that decouples the classifier from the fade sequencer.
// Depends on smf_pkg for its status struct.
`timescale 1ns / 1ps
`default_nettype none

module smf_queue
   import smf_pkg::*;
#(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output queue_stat_type        q_stat
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] ptr);
      if (ptr == PTR_BITS'(DEPTH - 1)) begin
         return '0;
      end
      return ptr + PTR_BITS'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign q_stat.full  = (count_ff == CNT_BITS'(DEPTH));
   assign q_stat.empty = (count_ff == '0);

endmodule

`default_nettype wire

[src/smf_arith.sv]
// Shared shift-subtract unit: fade fraction pos * 2^G / total one quotient
// bit a cycle, or floor(sqrt(rad * 2^G)) one root bit a cycle. Uses smf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smf_arith
   import smf_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 15,
   parameter int POSITION_BITS  = 20,
   localparam int GW = GAIN_FRAC_BITS + 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  arith_ctl_type                 ctl,
   input  wire logic [POSITION_BITS-1:0] num,
   input  wire logic [POSITION_BITS-1:0] den,
   input  wire logic [GW-1:0]            rad,
   output arith_stat_type                stat,
   output logic [GW-1:0]                 result
);

   localparam int G        = GAIN_FRAC_BITS;
   localparam int P        = POSITION_BITS;
   localparam int CNT_BITS = $clog2(G + 1);
   localparam int X_BITS   = 2 * G + 2;
   localparam int REM_BITS = G + 3;
   localparam int CAT_BITS = REM_BITS + 2;

   logic                busy_ff;
   logic                done_ff;
   logic                sqrt_ff;
   logic [CNT_BITS-1:0] count_ff;
   logic [GW-1:0]       res_ff;
   logic [P-1:0]        div_rem_ff, div_rem_in;
   logic [REM_BITS-1:0] sq_rem_ff, sq_rem_in;
   logic [X_BITS-1:0]   x_ff;
   logic                bit_in;
   logic                last_step;

   logic [P:0]          div_shift;
   logic [P:0]          div_diff;
   logic                div_ge;
   logic [CAT_BITS-1:0] sq_cat;
   logic [CAT_BITS-1:0] sq_trial;
   logic [CAT_BITS-1:0] sq_diff;
   logic                sq_ge;

   always_comb begin
      // remainder stays below den, so one spare bit holds the doubled value
      div_shift = {div_rem_ff, 1'b0};
      div_diff  = div_shift - {1'b0, den};
      div_ge    = (div_shift >= {1'b0, den});

      sq_cat    = {sq_rem_ff, x_ff[X_BITS-1 -: 2]};
      sq_trial  = {2'b00, res_ff, 2'b01};
      sq_diff   = sq_cat - sq_trial;
      sq_ge     = (sq_cat >= sq_trial);

      if (sqrt_ff) begin
         bit_in     = sq_ge;
         div_rem_in = div_rem_ff;
         sq_rem_in  = sq_ge ? sq_diff[REM_BITS-1:0] : sq_cat[REM_BITS-1:0];
         last_step  = (count_ff == CNT_BITS'(G));
      end else begin
         bit_in     = div_ge;
         div_rem_in = div_ge ? div_diff[P-1:0] : div_shift[P-1:0];
         sq_rem_in  = sq_rem_ff;
         last_step  = (count_ff == CNT_BITS'(G - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         sqrt_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff    <= 1'b1;
            sqrt_ff    <= ctl.is_sqrt;
            count_ff   <= '0;
            res_ff     <= '0;
            div_rem_ff <= num;
            sq_rem_ff  <= '0;
            x_ff       <= {1'b0, rad, G'(0)};
         end else if (busy_ff) begin
            res_ff     <= {res_ff[GW-2:0], bit_in};
            div_rem_ff <= div_rem_in;
            sq_rem_ff  <= sq_rem_in;
            x_ff       <= {x_ff[X_BITS-3:0], 2'b00};
            count_ff   <= count_ff + CNT_BITS'(1);
            if (last_step) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign result    = res_ff;

endmodule

`default_nettype wire

[src/smf_back.sv]
// Back end: fade sequencer. Holds the configuration, the fader state,
// position and gain, drives the arithmetic unit, scales both samples and
// owns the result register. Depends on smf_pkg and on smf_arith via ports.
`timescale 1ns / 1ps
`default_nettype none

module smf_back
   import smf_pkg::*;
#(
   parameter int SAMPLE_BITS    = 24,
   parameter int GAIN_FRAC_BITS = 15,
   parameter int POSITION_BITS  = 20,
   localparam int GW        = GAIN_FRAC_BITS + 1,
   localparam int ITEM_BITS = OP_BITS + 2 * SAMPLE_BITS + 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_we,
   input  wire logic [CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [POSITION_BITS-1:0]      csr_wdata,
   input  queue_stat_type                     q_stat,
   output logic                               pop,
   input  wire logic [ITEM_BITS-1:0]          pop_data,
   output arith_ctl_type                      arith_ctl,
   output logic [POSITION_BITS-1:0]           arith_num,
   output logic [POSITION_BITS-1:0]           arith_den,
   output logic [GW-1:0]                      arith_rad,
   input  arith_stat_type                     arith_stat,
   input  wire logic [GW-1:0]                 arith_result,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]      rsp_right_out,
   output logic [GW-1:0]                      rsp_gain_now,
   output logic [1:0]                         rsp_mute_state,
   output logic                               rsp_silent,
   output logic                               rsp_last_out
);

   localparam int S         = SAMPLE_BITS;
   localparam int G         = GAIN_FRAC_BITS;
   localparam int P         = POSITION_BITS;
   localparam int PROD_BITS = S + GW + 1;
   localparam logic [GW-1:0] GAIN_ONE  = {1'b1, {G{1'b0}}};
   // one percent of unity, rounded up
   localparam logic [GW-1:0] SILENT_LEVEL = GW'(((1 << G) + 99) / 100);

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_ROOT,
      S_SQUARE,
      S_SCALE,
      S_SEND
   } state_type;

   state_type        state_ff;
   mode_type         mode_ff;
   logic [P-1:0]     position_ff;
   logic [GW-1:0]    gain_ff;
   logic [P-1:0]     fade_len_ff;
   logic             curve_ff;
   logic             fo_ff;
   logic [GW-1:0]    g_ff;
   logic [G-1:0]     p_ff;
   logic [GW-1:0]    rad_ff;
   logic [S-1:0]     left_ff;
   logic [S-1:0]     right_ff;
   logic             last_ff;
   logic [S-1:0]     res_left_ff;
   logic [S-1:0]     res_right_ff;
   arith_ctl_type    arith_ctl_ff;
   logic             rsp_valid_ff;
   logic [S-1:0]     rsp_left_ff;
   logic [S-1:0]     rsp_right_ff;
   logic [GW-1:0]    rsp_gain_ff;
   logic [1:0]       rsp_mode_ff;
   logic             rsp_silent_ff;
   logic             rsp_last_ff;

   op_type           item_op;
   logic [S-1:0]     item_left;
   logic [S-1:0]     item_right;
   logic             item_last;
   logic [P-1:0]     total;
   logic             item_fo;
   logic [G-1:0]     frac;
   logic [2*G-1:0]   frac_sq;
   logic signed [PROD_BITS-1:0] prod_left;
   logic signed [PROD_BITS-1:0] prod_right;
   logic             silent_now;
   logic             send_free;

   always_comb begin
      item_op    = op_type'(pop_data[ITEM_BITS-1 -: OP_BITS]);
      item_left  = pop_data[2*S : S+1];
      item_right = pop_data[S:1];
      item_last  = pop_data[0];
      total      = (fade_len_ff == '0) ? P'(1) : fade_len_ff;
      item_fo    = (mode_ff == ST_FADE_OUT);
      frac       = arith_result[G-1:0];
      frac_sq    = p_ff * p_ff;
      prod_left  = $signed(left_ff) * $signed({1'b0, g_ff});
      prod_right = $signed(right_ff) * $signed({1'b0, g_ff});
      silent_now = (mode_ff == ST_MUTED) || ((mode_ff == ST_FADE_OUT) && (gain_ff < SILENT_LEVEL));
      send_free  = ~rsp_valid_ff | rsp_ready;
   end

   assign pop = (state_ff == S_IDLE) && !q_stat.empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         mode_ff      <= ST_PLAYING;
         position_ff  <= '0;
         gain_ff      <= GAIN_ONE;
         fade_len_ff  <= P'(FADE_SAMPLES_RESET);
         curve_ff     <= 1'b0;
         arith_ctl_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         arith_ctl_ff <= '0;

         if (csr_we) begin
            case (csr_index)
               CSR_FADE_SAMPLES: fade_len_ff <= csr_wdata;
               CSR_FADE_CURVE:   curve_ff    <= csr_wdata[0];
               default:          ;
            endcase
         end

         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (!q_stat.empty) begin
                  left_ff      <= item_left;
                  right_ff     <= item_right;
                  last_ff      <= item_last;
                  res_left_ff  <= '0;
                  res_right_ff <= '0;
                  state_ff     <= S_SEND;
                  case (item_op)
                     OP_FRAME: begin
                        if (mode_ff == ST_PLAYING) begin
                           res_left_ff  <= item_left;
                           res_right_ff <= item_right;
                        end else if (mode_ff == ST_MUTED) begin
                           gain_ff <= '0;
                        end else if (position_ff >= total) begin
                           // fade done: settle and apply the end gain
                           mode_ff  <= item_fo ? ST_MUTED : ST_PLAYING;
                           g_ff     <= item_fo ? '0 : GAIN_ONE;
                           state_ff <= S_SCALE;
                        end else begin
                           fo_ff                <= item_fo;
                           arith_ctl_ff.start   <= 1'b1;
                           arith_ctl_ff.is_sqrt <= 1'b0;
                           state_ff             <= S_DIV;
                        end
                     end
                     OP_FADE_OUT: begin
                        if (mode_ff inside {ST_PLAYING, ST_FADE_IN}) begin
                           position_ff <= '0;
                           mode_ff     <= ST_FADE_OUT;
                        end
                     end
                     OP_FADE_IN: begin
                        if (mode_ff inside {ST_MUTED, ST_FADE_OUT}) begin
                           position_ff <= '0;
                           mode_ff     <= ST_FADE_IN;
                        end
                     end
                     OP_MUTE: begin
                        mode_ff     <= ST_MUTED;
                        gain_ff     <= '0;
                        position_ff <= '0;
                     end
                     OP_PLAY: begin
                        mode_ff     <= ST_PLAYING;
                        gain_ff     <= GAIN_ONE;
                        position_ff <= '0;
                     end
                     default: ;
                  endcase
               end
            end
            S_DIV: begin
               if (arith_stat.done) begin
                  position_ff <= position_ff + P'(1);
                  if (!curve_ff) begin
                     g_ff     <= fo_ff ? (GAIN_ONE - {1'b0, frac}) : {1'b0, frac};
                     state_ff <= S_SCALE;
                  end else if (fo_ff) begin
                     rad_ff               <= GAIN_ONE - {1'b0, frac};
                     arith_ctl_ff.start   <= 1'b1;
                     arith_ctl_ff.is_sqrt <= 1'b1;
                     state_ff             <= S_ROOT;
                  end else begin
                     p_ff     <= frac;
                     state_ff <= S_SQUARE;
                  end
               end
            end
            S_ROOT: begin
               if (arith_stat.done) begin
                  g_ff     <= arith_result;
                  state_ff <= S_SCALE;
               end
            end
            S_SQUARE: begin
               g_ff     <= {1'b0, frac_sq[2*G-1:G]};
               state_ff <= S_SCALE;
            end
            S_SCALE: begin
               // floor shift: keep the bits above the gain fraction
               res_left_ff  <= prod_left[G +: S];
               res_right_ff <= prod_right[G +: S];
               gain_ff      <= g_ff;
               state_ff     <= S_SEND;
            end
            S_SEND: begin
               if (send_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_left_ff   <= res_left_ff;
                  rsp_right_ff  <= res_right_ff;
                  rsp_gain_ff   <= gain_ff;
                  rsp_mode_ff   <= mode_ff;
                  rsp_silent_ff <= silent_now;
                  rsp_last_ff   <= last_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign arith_ctl      = arith_ctl_ff;
   assign arith_num      = position_ff;
   assign arith_den      = total;
   assign arith_rad      = rad_ff;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_left_out   = rsp_left_ff;
   assign rsp_right_out  = rsp_right_ff;
   assign rsp_gain_now   = rsp_gain_ff;
   assign rsp_mute_state = rsp_mode_ff;
   assign rsp_silent     = rsp_silent_ff;
   assign rsp_last_out   = rsp_last_ff;

endmodule

`default_nettype wire
